// ===== rtl/i2cm_pkg.sv =====
// i2cm_pkg: shared types, constants and a helper function of the I2C master bit engine.
// No dependencies; every other file of the block uses it by scoped names.
`timescale 1ns / 1ps

package i2cm_pkg;

   localparam int DATA_BITS   = 8;
   localparam int STEP_W      = 5;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_READ  = 3'd4,
      CMD_SACK  = 3'd5,
      CMD_RACK  = 3'd6
   } cmd_type;

   // Position inside the three-action group of one data bit.
   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_SECOND = 2'd1,
      PH_THIRD  = 2'd2
   } phase_type;

   // One classified tick as it sits in the queue.
   typedef struct packed {
      cmd_type              cmd;
      logic                 load_en;
      logic [DATA_BITS-1:0] load_data;
      logic                 sda_sample;
   } tick_type;

   // Head of the queue as the back end sees it.
   typedef struct packed {
      logic     valid;
      tick_type tick;
   } queue_head_type;

   typedef struct packed {
      logic                 scl_level;
      logic                 sda_level;
      logic                 busy_res;
      logic                 done_res;
      logic [DATA_BITS-1:0] read_data;
      logic                 ack_received;
   } result_type;

   // Number of pin actions of each command sequence.
   function automatic logic [STEP_W-1:0] seq_length(cmd_type cmd);
      logic [STEP_W-1:0] len;
      unique case (cmd)
         CMD_START: len = STEP_W'(4);
         CMD_STOP:  len = STEP_W'(3);
         CMD_WRITE: len = STEP_W'(3 * DATA_BITS);
         CMD_READ:  len = STEP_W'(1 + 3 * DATA_BITS);
         CMD_SACK:  len = STEP_W'(3);
         CMD_RACK:  len = STEP_W'(4);
         default:   len = '0;
      endcase
      return len;
   endfunction

endpackage

// ===== rtl/i2cm_if.sv =====
// i2cm_if: valid/ready channel interfaces for the tick requests and the tick results.
// Depends on i2cm_pkg for the data width.
`timescale 1ns / 1ps

interface i2cm_req_if;
   logic                           valid;
   logic                           ready;
   logic [2:0]                     command;
   logic [i2cm_pkg::DATA_BITS-1:0] write_data;
   logic                           ack_to_send;
   logic                           sda_sample;

   modport source (output valid, command, write_data, ack_to_send, sda_sample, input ready);
   modport sink   (input valid, command, write_data, ack_to_send, sda_sample, output ready);
endinterface

interface i2cm_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           scl_level;
   logic                           sda_level;
   logic                           busy_res;
   logic                           done_res;
   logic [i2cm_pkg::DATA_BITS-1:0] read_data;
   logic                           ack_received;

   modport source (output valid, scl_level, sda_level, busy_res, done_res, read_data,
                   ack_received, input ready);
   modport sink   (input valid, scl_level, sda_level, busy_res, done_res, read_data,
                   ack_received, output ready);
endinterface

// ===== rtl/i2c_master_bit_engine.sv =====
// i2c_master_bit_engine: top level of the I2C master bit engine, front end, queue and back end.
// Depends on i2cm_pkg, i2cm_if, i2cm_front and i2cm_back.
`timescale 1ns / 1ps
//
//   Channel   Direction  Carries
//   -------   ---------  -------------------------------------------------------------
//   req_bus   in         one timing tick: command, write_data, ack_to_send, sda_sample
//   rsp_bus   out        one result per tick: scl_level, sda_level, busy_res, done_res,
//                        read_data, ack_received
//
// The engine takes one tick beat every clock cycle unless the queue is full and returns
// one result beat for each. A beat enters the tick queue at the
// accepting edge, the back end performs its pin action from the queue head, and the result
// is registered for rsp_bus. The single sequencer in the back end sets the rate. Reset is
// synchronous: the queue and the result register empty, both lines read released and no
// command is active. A stall on rsp_bus holds the result register and the sequencer; the
// queue keeps taking ticks until it is full, then drops req_bus.ready.

module i2c_master_bit_engine #(
   parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   i2cm_req_if.sink          req_bus,
   i2cm_rsp_if.source        rsp_bus
);

   // Head of the tick queue, seen by the back end.
   i2cm_pkg::queue_head_type head;
   // Back end takes the head tick this cycle.
   logic                     pop;
   // Registered result beat.
   i2cm_pkg::result_type     result;

   // Front end: decodes each command and parks the classified tick in the queue.
   i2cm_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_bus.valid),
      .in_ready       (req_bus.ready),
      .in_command     (req_bus.command),
      .in_write_data  (req_bus.write_data),
      .in_ack_to_send (req_bus.ack_to_send),
      .in_sda_sample  (req_bus.sda_sample),
      .head           (head),
      .pop            (pop)
   );

   // Back end: one pin action per tick, result held until the sink takes it.
   i2cm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (result)
   );

   assign rsp_bus.scl_level    = result.scl_level;
   assign rsp_bus.sda_level    = result.sda_level;
   assign rsp_bus.busy_res     = result.busy_res;
   assign rsp_bus.done_res     = result.done_res;
   assign rsp_bus.read_data    = result.read_data;
   assign rsp_bus.ack_received = result.ack_received;

endmodule

// ===== rtl/i2cm_front.sv =====
// i2cm_front: accepts request beats, decodes the command and queues the classified tick.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_front #(
   parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [2:0]                     in_command,
   input  logic [i2cm_pkg::DATA_BITS-1:0] in_write_data,
   input  logic                           in_ack_to_send,
   input  logic                           in_sda_sample,
   output i2cm_pkg::queue_head_type       head,
   input  logic                           pop
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   i2cm_pkg::tick_type entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   i2cm_pkg::tick_type tick;
   logic               push;
   logic               do_pop;

   // Classify the command; unknown codes become no command.
   always_comb begin
      tick.load_en    = 1'b0;
      tick.load_data  = '0;
      tick.sda_sample = in_sda_sample;
      unique case (in_command)
         i2cm_pkg::CMD_START: tick.cmd = i2cm_pkg::CMD_START;
         i2cm_pkg::CMD_STOP:  tick.cmd = i2cm_pkg::CMD_STOP;
         i2cm_pkg::CMD_WRITE: begin
            tick.cmd       = i2cm_pkg::CMD_WRITE;
            tick.load_en   = 1'b1;
            tick.load_data = in_write_data;
         end
         i2cm_pkg::CMD_READ: begin
            tick.cmd     = i2cm_pkg::CMD_READ;
            tick.load_en = 1'b1;
         end
         i2cm_pkg::CMD_SACK: begin
            tick.cmd       = i2cm_pkg::CMD_SACK;
            tick.load_en   = 1'b1;
            tick.load_data = {{(i2cm_pkg::DATA_BITS-1){1'b0}}, in_ack_to_send};
         end
         i2cm_pkg::CMD_RACK: tick.cmd = i2cm_pkg::CMD_RACK;
         default: tick.cmd = i2cm_pkg::CMD_NONE;
      endcase
   end

   assign in_ready   = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push       = in_valid && in_ready;
   assign head.valid = (count_ff != '0);
   assign head.tick  = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= tick;
      end
   end

endmodule

// ===== rtl/i2cm_back.sv =====
// i2cm_back: runs the command sequences one pin action per tick and registers each result.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_back (
   input  logic                     clock,
   input  logic                     reset,
   input  i2cm_pkg::queue_head_type head,
   output logic                     pop,
   output logic                     out_valid,
   input  logic                     out_ready,
   output i2cm_pkg::result_type     out_data
);

   localparam int DW = i2cm_pkg::DATA_BITS;
   localparam int SW = i2cm_pkg::STEP_W;

   i2cm_pkg::cmd_type    active_ff, active_in;
   logic [SW-1:0]        step_ff, step_in;
   i2cm_pkg::phase_type  phase_ff, phase_in;
   logic [DW-1:0]        shift_ff, shift_in;
   logic [DW-1:0]        rbyte_ff, rbyte_in;
   logic                 rack_ff, rack_in;
   logic                 scl_ff, scl_in;
   logic                 sda_ff, sda_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   i2cm_pkg::result_type rsp_data_ff, rsp_data_in;

   logic                 start;
   i2cm_pkg::cmd_type    cmd_eff;
   logic [SW-1:0]        step_eff;
   logic [SW-1:0]        step_next;
   i2cm_pkg::phase_type  phase_eff;
   logic [DW-1:0]        shift_eff;
   logic                 last;

   assign pop = head.valid && (!rsp_valid_ff || out_ready);

   // A command is taken only while idle; its first action runs on the same tick.
   always_comb begin
      start     = (active_ff == i2cm_pkg::CMD_NONE) && (head.tick.cmd != i2cm_pkg::CMD_NONE);
      cmd_eff   = start ? head.tick.cmd : active_ff;
      step_eff  = start ? '0 : step_ff;
      phase_eff = start ? i2cm_pkg::PH_FIRST : phase_ff;
      shift_eff = (start && head.tick.load_en) ? head.tick.load_data : shift_ff;
      step_next = step_eff + SW'(1);
      last      = (cmd_eff != i2cm_pkg::CMD_NONE) &&
                  (step_next >= i2cm_pkg::seq_length(cmd_eff));
   end

   // Next state of the sequencer.
   always_comb begin
      active_in = last ? i2cm_pkg::CMD_NONE : cmd_eff;
      step_in   = (last || cmd_eff == i2cm_pkg::CMD_NONE) ? '0 : step_next;
      if (cmd_eff == i2cm_pkg::CMD_READ && step_eff == '0) begin
         phase_in = i2cm_pkg::PH_FIRST;
      end else begin
         unique case (phase_eff)
            i2cm_pkg::PH_FIRST:  phase_in = i2cm_pkg::PH_SECOND;
            i2cm_pkg::PH_SECOND: phase_in = i2cm_pkg::PH_THIRD;
            default:             phase_in = i2cm_pkg::PH_FIRST;
         endcase
      end
   end

   // Pin actions and data path.
   always_comb begin
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      shift_in = shift_eff;
      rack_in  = rack_ff;
      unique case (cmd_eff)
         i2cm_pkg::CMD_START: begin
            case (step_eff)
               SW'(0):  sda_in = 1'b1;
               SW'(1):  scl_in = 1'b1;
               SW'(2):  sda_in = 1'b0;
               default: scl_in = 1'b0;
            endcase
         end
         i2cm_pkg::CMD_STOP: begin
            case (step_eff)
               SW'(0):  sda_in = 1'b0;
               SW'(1):  scl_in = 1'b1;
               default: sda_in = 1'b1;
            endcase
         end
         i2cm_pkg::CMD_WRITE: begin
            case (phase_eff)
               i2cm_pkg::PH_FIRST:  sda_in = shift_eff[DW-1];
               i2cm_pkg::PH_SECOND: scl_in = 1'b1;
               default: begin
                  scl_in   = 1'b0;
                  shift_in = {shift_eff[DW-2:0], 1'b0};
               end
            endcase
         end
         i2cm_pkg::CMD_READ: begin
            if (step_eff == '0) begin
               sda_in = 1'b1;
            end else begin
               case (phase_eff)
                  i2cm_pkg::PH_FIRST:  scl_in = 1'b1;
                  i2cm_pkg::PH_SECOND: shift_in = {shift_eff[DW-2:0], head.tick.sda_sample};
                  default:             scl_in = 1'b0;
               endcase
            end
         end
         i2cm_pkg::CMD_SACK: begin
            case (step_eff)
               SW'(0):  sda_in = shift_eff[0];
               SW'(1):  scl_in = 1'b1;
               default: scl_in = 1'b0;
            endcase
         end
         i2cm_pkg::CMD_RACK: begin
            case (step_eff)
               SW'(0):  sda_in = 1'b1;
               SW'(1):  scl_in = 1'b1;
               SW'(2):  rack_in = head.tick.sda_sample;
               default: scl_in = 1'b0;
            endcase
         end
         default: ;
      endcase
      rbyte_in = (last && cmd_eff == i2cm_pkg::CMD_READ) ? shift_in : rbyte_ff;

      rsp_data_in.scl_level    = scl_in;
      rsp_data_in.sda_level    = sda_in;
      rsp_data_in.busy_res     = (active_in != i2cm_pkg::CMD_NONE);
      rsp_data_in.done_res     = last;
      rsp_data_in.read_data    = rbyte_in;
      rsp_data_in.ack_received = rack_in;
      rsp_valid_in = pop || (rsp_valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= i2cm_pkg::CMD_NONE;
         step_ff      <= '0;
         phase_ff     <= i2cm_pkg::PH_FIRST;
         shift_ff     <= '0;
         rbyte_ff     <= '0;
         rack_ff      <= 1'b0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            active_ff <= active_in;
            step_ff   <= step_in;
            phase_ff  <= phase_in;
            shift_ff  <= shift_in;
            rbyte_ff  <= rbyte_in;
            rack_ff   <= rack_in;
            scl_ff    <= scl_in;
            sda_ff    <= sda_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_data_ff;

endmodule

// ===== rtl/i2cm_checker.sv =====
// i2cm_checker: port-level checks of the I2C master bit engine, bound to its top level.
// Depends on i2cm_pkg, i2cm_if and i2c_master_bit_engine.
`timescale 1ns / 1ps

module i2cm_checker (
   input  logic       clock,
   input  logic       reset,
   i2cm_req_if.sink   req_bus,
   i2cm_rsp_if.source rsp_bus
);

   logic                           seen_ff;
   logic [i2cm_pkg::DATA_BITS-1:0] last_rdata_ff;
   logic                           rsp_beat;

   assign rsp_beat = rsp_bus.valid && rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_beat) begin
         seen_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_beat) begin
         last_rdata_ff <= rsp_bus.read_data;
      end
   end

   // A stalled result beat stays and keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=>
         rsp_bus.valid && $stable(rsp_bus.scl_level) && $stable(rsp_bus.sda_level) &&
         $stable(rsp_bus.busy_res) && $stable(rsp_bus.done_res) &&
         $stable(rsp_bus.read_data) && $stable(rsp_bus.ack_received))
      else $error("result beat changed while stalled");

   // The finishing tick of a sequence leaves the engine idle.
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !(rsp_bus.done_res && rsp_bus.busy_res))
      else $error("done and busy reported together");

   // No result beat directly after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("result beat right after reset");

   // The received byte only changes on a finishing tick.
   a_rdata_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && seen_ff && (rsp_bus.read_data != last_rdata_ff) |->
         rsp_bus.done_res)
      else $error("read_data changed outside a finishing tick");

   // The request ready is always a defined level once reset is over.
   a_req_ready_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown(req_bus.ready))
      else $error("request ready is unknown");

endmodule

bind i2c_master_bit_engine i2cm_checker u_checker (
   .clock   (clock),
   .reset   (reset),
   .req_bus (req_bus),
   .rsp_bus (rsp_bus)
);

// ===== sim/testbench.sv =====
// testbench: self-checking bench for the I2C master bit engine, driving ticks and checking results.
// Depends on i2cm_pkg, the i2cm_req_if/i2cm_rsp_if interfaces and the i2c_master_bit_engine RTL.
`timescale 1ns / 1ps

module testbench;

   localparam int DATA_BITS = i2cm_pkg::DATA_BITS;
   localparam int STEP_W    = i2cm_pkg::STEP_W;

   // Command code that the engine must treat as no command.
   localparam logic [2:0] CMD_UNUSED = 3'd7;

   // How the SDA level is chosen for the ticks of one command sequence.
   localparam int SDA_LOW    = 0;
   localparam int SDA_HIGH   = 1;
   localparam int SDA_RANDOM = 2;

   // The random part stops once this many ticks have fallen inside a sequence.
   localparam int TICK_TARGET = 1900;

   // One tick beat as the bench builds it.
   typedef struct packed {
      logic [2:0]           command;
      logic [DATA_BITS-1:0] write_data;
      logic                 ack_to_send;
      logic                 sda_sample;
   } tick_beat_type;

   logic clock = 1'b0;
   logic reset;

   i2cm_req_if req_bus ();
   i2cm_rsp_if rsp_bus ();

   i2c_master_bit_engine dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #10 clock = ~clock;

   // Shadow copy of the engine state. It is advanced once for every accepted tick beat,
   // in acceptance order, which is also the order in which results come back.
   i2cm_pkg::cmd_type    eng_cmd;
   logic [STEP_W-1:0]    eng_step;
   logic [DATA_BITS-1:0] eng_shift;
   logic [DATA_BITS-1:0] eng_rx_byte;
   logic                 eng_rx_ack;
   logic                 eng_scl;
   logic                 eng_sda;

   i2cm_pkg::result_type pin_results_due[$];

   // When cleared, neither side inserts gaps or stalls.
   bit idling_on = 1'b1;

   int error_count    = 0;
   int ticks_sent     = 0;
   int seq_ticks      = 0;
   int beats_checked  = 0;
   int done_seen      = 0;
   int bytes_read     = 0;

   // Outputs of the engine are sampled in the middle of the cycle, where they are stable,
   // and used at the next rising edge. Inputs only change right after rising edges.
   logic                 req_ready_seen;
   logic                 rsp_valid_seen;
   i2cm_pkg::result_type rsp_seen;

   always @(negedge clock) begin
      req_ready_seen = req_bus.ready;
      rsp_valid_seen = rsp_bus.valid;
      rsp_seen.scl_level    = rsp_bus.scl_level;
      rsp_seen.sda_level    = rsp_bus.sda_level;
      rsp_seen.busy_res     = rsp_bus.busy_res;
      rsp_seen.done_res     = rsp_bus.done_res;
      rsp_seen.read_data    = rsp_bus.read_data;
      rsp_seen.ack_received = rsp_bus.ack_received;
   end

   // Advances the shadow engine by one tick and returns the pin levels and flags it
   // should report for that tick.
   task automatic step_engine(input tick_beat_type t, output i2cm_pkg::result_type r);
      logic [STEP_W-1:0] seq_len;
      logic              done;
      done = 1'b0;
      // A new command is only taken while idle; code 7 counts as no command.
      if (eng_cmd == i2cm_pkg::CMD_NONE && t.command >= i2cm_pkg::CMD_START &&
          t.command <= i2cm_pkg::CMD_RACK) begin
         eng_cmd  = i2cm_pkg::cmd_type'(t.command);
         eng_step = '0;
         case (eng_cmd)
            i2cm_pkg::CMD_WRITE: eng_shift = t.write_data;
            i2cm_pkg::CMD_SACK:  eng_shift = {{(DATA_BITS-1){1'b0}}, t.ack_to_send};
            i2cm_pkg::CMD_READ:  eng_shift = '0;
            default: ;
         endcase
      end
      if (eng_cmd != i2cm_pkg::CMD_NONE) begin
         // One pin action per tick. Write and read work in groups of three per bit;
         // read first releases SDA, so its groups start one step later.
         case (eng_cmd)
            i2cm_pkg::CMD_START: begin
               case (eng_step)
                  0: eng_sda = 1'b1;
                  1: eng_scl = 1'b1;
                  2: eng_sda = 1'b0;
                  default: eng_scl = 1'b0;
               endcase
            end
            i2cm_pkg::CMD_STOP: begin
               case (eng_step)
                  0: eng_sda = 1'b0;
                  1: eng_scl = 1'b1;
                  default: eng_sda = 1'b1;
               endcase
            end
            i2cm_pkg::CMD_WRITE: begin
               case (eng_step % 3)
                  0: eng_sda = eng_shift[DATA_BITS-1];
                  1: eng_scl = 1'b1;
                  default: begin
                     eng_scl   = 1'b0;
                     eng_shift = {eng_shift[DATA_BITS-2:0], 1'b0};
                  end
               endcase
            end
            i2cm_pkg::CMD_READ: begin
               if (eng_step == 0) begin
                  eng_sda = 1'b1;
               end else begin
                  case ((eng_step - 1) % 3)
                     0: eng_scl = 1'b1;
                     1: eng_shift = {eng_shift[DATA_BITS-2:0], t.sda_sample};
                     default: eng_scl = 1'b0;
                  endcase
               end
            end
            i2cm_pkg::CMD_SACK: begin
               case (eng_step)
                  0: eng_sda = eng_shift[0];
                  1: eng_scl = 1'b1;
                  default: eng_scl = 1'b0;
               endcase
            end
            i2cm_pkg::CMD_RACK: begin
               case (eng_step)
                  0: eng_sda = 1'b1;
                  1: eng_scl = 1'b1;
                  2: eng_rx_ack = t.sda_sample;
                  default: eng_scl = 1'b0;
               endcase
            end
            default: ;
         endcase
         eng_step = eng_step + 1'b1;
         case (eng_cmd)
            i2cm_pkg::CMD_START: seq_len = STEP_W'(4);
            i2cm_pkg::CMD_WRITE: seq_len = STEP_W'(3 * DATA_BITS);
            i2cm_pkg::CMD_READ:  seq_len = STEP_W'(1 + 3 * DATA_BITS);
            i2cm_pkg::CMD_RACK:  seq_len = STEP_W'(4);
            default:             seq_len = STEP_W'(3);
         endcase
         if (eng_step >= seq_len) begin
            if (eng_cmd == i2cm_pkg::CMD_READ) begin
               eng_rx_byte = eng_shift;
               bytes_read++;
            end
            eng_cmd  = i2cm_pkg::CMD_NONE;
            eng_step = '0;
            done     = 1'b1;
         end
      end
      r.scl_level    = eng_scl;
      r.sda_level    = eng_sda;
      r.busy_res     = (eng_cmd != i2cm_pkg::CMD_NONE);
      r.done_res     = done;
      r.read_data    = eng_rx_byte;
      r.ack_received = eng_rx_ack;
   endtask

   // Offers one tick beat, at times after a random gap, and holds it until the
   // engine takes it. The expected result is queued at the accepting edge.
   task automatic send_tick(input logic [2:0] command, input logic [DATA_BITS-1:0] data,
                            input logic ack, input logic sda);
      tick_beat_type        beat;
      i2cm_pkg::result_type want;
      beat = '{command: command, write_data: data, ack_to_send: ack, sda_sample: sda};
      if (idling_on && $urandom_range(0, 99) < 34) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.command     <= beat.command;
      req_bus.write_data  <= beat.write_data;
      req_bus.ack_to_send <= beat.ack_to_send;
      req_bus.sda_sample  <= beat.sda_sample;
      @(posedge clock);
      while (!req_ready_seen) @(posedge clock);
      step_engine(beat, want);
      pin_results_due.push_back(want);
      ticks_sent++;
      if (want.busy_res || want.done_res) seq_ticks++;
   endtask

   function automatic logic sda_for(input int policy);
      if (policy == SDA_RANDOM) return logic'($urandom_range(0, 1));
      return logic'(policy == SDA_HIGH);
   endfunction

   // Issues one command and keeps ticking until its sequence is over. With noise on,
   // the ticks in between carry random commands, which a busy engine must ignore.
   task automatic run_command(input logic [2:0] command, input logic [DATA_BITS-1:0] data,
                              input logic ack, input int sda_policy, input bit noisy);
      send_tick(command, data, ack, sda_for(sda_policy));
      while (eng_cmd != i2cm_pkg::CMD_NONE) begin
         send_tick(noisy ? 3'($urandom_range(0, 7)) : i2cm_pkg::CMD_NONE, 8'($urandom),
                   1'($urandom), sda_for(sda_policy));
      end
   endtask

   // One well-formed bus transfer: start, address, acked data bytes in the direction the
   // address selects, an optional repeated start, and stop.
   task automatic run_transfer(input bit noisy);
      logic [DATA_BITS-1:0] address;
      int                   byte_total;
      address    = 8'($urandom);
      byte_total = $urandom_range(1, 3);
      run_command(i2cm_pkg::CMD_START, 8'($urandom), 1'($urandom), SDA_RANDOM, noisy);
      run_command(i2cm_pkg::CMD_WRITE, address, 1'($urandom), SDA_RANDOM, noisy);
      run_command(i2cm_pkg::CMD_RACK, 8'($urandom), 1'($urandom),
                  ($urandom_range(0, 9) == 0) ? SDA_HIGH : SDA_LOW, noisy);
      for (int n = 0; n < byte_total; n++) begin
         if (address[0]) begin
            run_command(i2cm_pkg::CMD_READ, 8'($urandom), 1'($urandom), SDA_RANDOM, noisy);
            // The last byte of a read is answered with a not-acknowledge.
            run_command(i2cm_pkg::CMD_SACK, 8'($urandom), (n == byte_total - 1), SDA_RANDOM,
                        noisy);
         end else begin
            run_command(i2cm_pkg::CMD_WRITE, 8'($urandom), 1'($urandom), SDA_RANDOM, noisy);
            run_command(i2cm_pkg::CMD_RACK, 8'($urandom), 1'($urandom), SDA_RANDOM, noisy);
         end
      end
      if ($urandom_range(0, 4) == 0) begin
         run_command(i2cm_pkg::CMD_START, 8'($urandom), 1'($urandom), SDA_RANDOM, noisy);
         run_command(i2cm_pkg::CMD_WRITE, 8'($urandom), 1'($urandom), SDA_RANDOM, noisy);
      end
      run_command(i2cm_pkg::CMD_STOP, 8'($urandom), 1'($urandom), SDA_RANDOM, noisy);
   endtask

   // Idle ticks with no command or with the unused code 7: the pins must hold and the
   // flags must stay low, whatever SDA does.
   task automatic test_idle_hold();
      send_tick(i2cm_pkg::CMD_NONE, 8'h00, 1'b0, 1'b0);
      send_tick(i2cm_pkg::CMD_NONE, 8'hFF, 1'b1, 1'b1);
      send_tick(CMD_UNUSED, 8'hFF, 1'b1, 1'b0);
      send_tick(CMD_UNUSED, 8'h00, 1'b0, 1'b1);
   endtask

   // Every command once or twice, with extreme data, both ack levels and both line levels.
   task automatic test_each_command();
      run_command(i2cm_pkg::CMD_START, 8'h00, 1'b0, SDA_LOW, 1'b0);
      run_command(i2cm_pkg::CMD_WRITE, 8'hFF, 1'b0, SDA_LOW, 1'b0);
      run_command(i2cm_pkg::CMD_WRITE, 8'h00, 1'b1, SDA_HIGH, 1'b0);
      run_command(i2cm_pkg::CMD_RACK, 8'h00, 1'b0, SDA_LOW, 1'b0);
      run_command(i2cm_pkg::CMD_RACK, 8'h00, 1'b0, SDA_HIGH, 1'b0);
      run_command(i2cm_pkg::CMD_READ, 8'hFF, 1'b1, SDA_HIGH, 1'b0);
      run_command(i2cm_pkg::CMD_READ, 8'h00, 1'b0, SDA_LOW, 1'b0);
      run_command(i2cm_pkg::CMD_SACK, 8'hFF, 1'b0, SDA_HIGH, 1'b0);
      run_command(i2cm_pkg::CMD_SACK, 8'h00, 1'b1, SDA_LOW, 1'b0);
      run_command(i2cm_pkg::CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
   endtask

   // Commands arriving while a sequence runs must not disturb it, and a command right
   // after a done pulse must be taken.
   task automatic test_busy_commands();
      run_command(i2cm_pkg::CMD_START, 8'hA5, 1'b1, SDA_RANDOM, 1'b1);
      run_command(i2cm_pkg::CMD_WRITE, 8'hA5, 1'b1, SDA_RANDOM, 1'b1);
      run_command(i2cm_pkg::CMD_READ, 8'h5A, 1'b0, SDA_RANDOM, 1'b1);
      run_command(i2cm_pkg::CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b1);
   endtask

   // Transfers with no gaps on the request side and no stalls on the result side.
   task automatic test_streaming();
      idling_on = 1'b0;
      repeat (4) run_transfer(1'($urandom_range(0, 1)));
      idling_on = 1'b1;
   endtask

   // Mostly well-formed transfers with random content; the rest are lone commands
   // and stray idle ticks.
   task automatic test_random_traffic();
      int pick;
      while (seq_ticks < TICK_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            run_transfer($urandom_range(0, 99) < 30);
         end else if (pick < 90) begin
            run_command(3'($urandom_range(i2cm_pkg::CMD_START, i2cm_pkg::CMD_RACK)),
                        8'($urandom), 1'($urandom), SDA_RANDOM,
                        1'($urandom_range(0, 1)));
         end else begin
            repeat ($urandom_range(1, 4)) begin
               send_tick(($urandom_range(0, 1) != 0) ? CMD_UNUSED : i2cm_pkg::CMD_NONE,
                         8'($urandom), 1'($urandom), 1'($urandom));
            end
         end
      end
   endtask

   // Result side: each accepted result beat is compared with the oldest expectation,
   // then the ready for the next edge is chosen.
   always @(posedge clock) begin
      i2cm_pkg::result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_valid_seen && rsp_bus.ready) begin
            if (pin_results_due.size() == 0) begin
               $error("result beat arrived with no tick outstanding");
               error_count++;
            end else begin
               want = pin_results_due.pop_front();
               beats_checked++;
               if (rsp_seen.done_res) done_seen++;
               if (rsp_seen.scl_level !== want.scl_level) begin
                  $error("scl_level: expected %0d, got %0d", want.scl_level, rsp_seen.scl_level);
                  error_count++;
               end
               if (rsp_seen.sda_level !== want.sda_level) begin
                  $error("sda_level: expected %0d, got %0d", want.sda_level, rsp_seen.sda_level);
                  error_count++;
               end
               if (rsp_seen.busy_res !== want.busy_res) begin
                  $error("busy_res: expected %0d, got %0d", want.busy_res, rsp_seen.busy_res);
                  error_count++;
               end
               if (rsp_seen.done_res !== want.done_res) begin
                  $error("done_res: expected %0d, got %0d", want.done_res, rsp_seen.done_res);
                  error_count++;
               end
               if (rsp_seen.read_data !== want.read_data) begin
                  $error("read_data: expected 0x%02h, got 0x%02h", want.read_data,
                         rsp_seen.read_data);
                  error_count++;
               end
               if (rsp_seen.ack_received !== want.ack_received) begin
                  $error("ack_received: expected %0d, got %0d", want.ack_received,
                         rsp_seen.ack_received);
                  error_count++;
               end
            end
         end
         rsp_bus.ready <= idling_on ? ($urandom_range(0, 99) >= 34) : 1'b1;
      end
   end

   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.command     = i2cm_pkg::CMD_NONE;
      req_bus.write_data  = '0;
      req_bus.ack_to_send = 1'b0;
      req_bus.sda_sample  = 1'b0;
      // Shadow state matches the engine after reset: idle, both lines released.
      eng_cmd     = i2cm_pkg::CMD_NONE;
      eng_step    = '0;
      eng_shift   = '0;
      eng_rx_byte = '0;
      eng_rx_ack  = 1'b0;
      eng_scl     = 1'b1;
      eng_sda     = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_hold();
      test_each_command();
      test_busy_commands();
      test_streaming();
      test_random_traffic();

      // Drop valid on the edge that took the last beat so it is not taken twice.
      req_bus.valid <= 1'b0;
      while (pin_results_due.size() != 0) @(posedge clock);
      // Any stray beat would show up well within this wait.
      repeat (8) @(posedge clock);
      if (pin_results_due.size() != 0) begin
         $error("%0d expected result beats never arrived", pin_results_due.size());
         error_count++;
      end

      $display("Sent %0d tick beats, %0d of them inside a command sequence, and checked %0d",
               ticks_sent, seq_ticks, beats_checked);
      $display("result beats covering %0d finished commands, %0d of them byte reads.",
               done_seen, bytes_read);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog: far longer than the slowest correct run needs.
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== i2c_master_bit_engine.f =====
rtl/i2cm_pkg.sv
rtl/i2cm_if.sv
rtl/i2cm_front.sv
rtl/i2cm_back.sv
rtl/i2c_master_bit_engine.sv
rtl/i2cm_checker.sv
sim/testbench.sv
